FILE: sv/mxb_pkg.sv
// ----------------------------------------------------------------------------
// mxb_pkg
// Shared types, codes and constants of the address-xor pattern memory
// self-test sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package mxb_pkg;

    // default bytes per memory word
    localparam int DEF_WORD_BYTES = 8;
    // address space width, addresses wrap at this size
    localparam int ADDR_BITS = 48;

    // field widths
    localparam int FIELD_ADDR_W = 48;
    localparam int DATA_W       = 64;
    localparam int LEN_W        = 32;
    localparam int CFG_IDX_W    = 2;

    // address wrap mask
    localparam logic [FIELD_ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= FIELD_ADDR_W) ?
        {FIELD_ADDR_W{1'b1}} : FIELD_ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

    // test patterns
    localparam logic [DATA_W-1:0] PAT_FIRST  = 64'hA55AA55AA55AA55A;
    localparam logic [DATA_W-1:0] PAT_SECOND = 64'h5AA55AA55AA55AA5;
    localparam logic [DATA_W-1:0] BYTE_MASK  = 64'h00000000000000FF;

    // sequencer phases
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_WWRITE = 3'd1;
    localparam logic [2:0] PH_WREAD  = 3'd2;
    localparam logic [2:0] PH_BWRITE = 3'd3;
    localparam logic [2:0] PH_BREAD  = 3'd4;

    // memory operations
    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_WWORD  = 3'd1;
    localparam logic [2:0] OP_RWORD  = 3'd2;
    localparam logic [2:0] OP_WBYTE  = 3'd3;
    localparam logic [2:0] OP_RBYTE  = 3'd4;

    // status codes
    localparam logic [1:0] ST_RUN     = 2'd0;
    localparam logic [1:0] ST_PASS    = 2'd1;
    localparam logic [1:0] ST_FAIL    = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    // commands
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd1;

    // input word
    typedef struct packed {
        logic              cmd;
        logic [DATA_W-1:0] read_data;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [2:0]              mem_op;
        logic [FIELD_ADDR_W-1:0] mem_addr;
        logic [DATA_W-1:0]       write_data;
        logic [1:0]              status;
        logic [FIELD_ADDR_W-1:0] fail_address;
        logic                    done_res;
    } t_out_word;

    // region settings and derived counts
    typedef struct packed {
        logic [FIELD_ADDR_W-1:0] base;
        logic [LEN_W-1:0]        length;
        logic [LEN_W-1:0]        word_cnt;
        logic [LEN_W-1:0]        tail_start;
        logic                    has_word;
        logic                    has_tail;
    } t_cfg;

    // sequencer state
    typedef struct packed {
        logic [2:0]              phase;
        logic                    pat_sel;
        logic [LEN_W-1:0]        idx;
        logic [DATA_W-1:0]       pend_exp;
        logic [FIELD_ADDR_W-1:0] pend_addr;
        logic                    pend_rd;
        logic [FIELD_ADDR_W-1:0] fail_addr;
        logic [1:0]              final_status;
    } t_state;

endpackage

`default_nettype wire

FILE: sv/mxb_cfg.sv
// ----------------------------------------------------------------------------
// mxb_cfg
// Region registers with the word count and tail start derived on write.
// ----------------------------------------------------------------------------
`default_nettype none

module mxb_cfg
    import mxb_pkg::*;
#(
    parameter int WORD_BYTES = DEF_WORD_BYTES
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [FIELD_ADDR_W-1:0] i_cfg_data,
    output t_cfg                         o_cfg
);

    // reciprocal of the word size, exact for every 32-bit length
    localparam int RCP_SHIFT = LEN_W + 3;
    localparam logic [RCP_SHIFT-1:0] RCP_MUL =
        RCP_SHIFT'((64'd1 << RCP_SHIFT) / WORD_BYTES + 64'd1);
    localparam int PROD_W = LEN_W + RCP_SHIFT;

    logic [FIELD_ADDR_W-1:0] r_base;
    logic [LEN_W-1:0]        r_length;
    logic [LEN_W-1:0]        r_word_cnt;
    logic [LEN_W-1:0]        r_tail0;
    logic [LEN_W-1:0]        wr_len;
    logic [PROD_W-1:0]       rcp_prod;

    // length divided by the word size
    assign wr_len   = i_cfg_data[LEN_W-1:0];
    assign rcp_prod = PROD_W'(wr_len) * PROD_W'(RCP_MUL);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= '0;
            r_length   <= '0;
            r_word_cnt <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BASE: begin
                    r_base <= i_cfg_data;
                end
                CFG_LENGTH: begin
                    r_length   <= wr_len;
                    r_word_cnt <= rcp_prod[PROD_W-1:RCP_SHIFT];
                end
                default: begin
                end
            endcase
        end
    end

    // first tail byte offset, registered from the word count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail0 <= '0;
        end else begin
            r_tail0 <= LEN_W'(r_word_cnt * LEN_W'(WORD_BYTES));
        end
    end

    // with no whole word the tail starts at zero and is the whole region
    always_comb begin
        o_cfg.base       = r_base;
        o_cfg.length     = r_length;
        o_cfg.word_cnt   = r_word_cnt;
        o_cfg.has_word   = (r_word_cnt != '0);
        o_cfg.tail_start = (r_word_cnt == '0) ? '0 : r_tail0;
        o_cfg.has_tail   = (r_word_cnt == '0) ? (r_length != '0) : (r_tail0 != r_length);
    end

endmodule

`default_nettype wire

FILE: sv/mxb_step.sv
// ----------------------------------------------------------------------------
// mxb_step
// One sequencer step: read compare, phase advance and next memory operation.
// ----------------------------------------------------------------------------
`default_nettype none

module mxb_step
    import mxb_pkg::*;
#(
    parameter int WORD_BYTES = DEF_WORD_BYTES
) (
    input  t_cfg      i_cfg,
    input  t_state    i_state,
    input  t_in_word  i_word,
    output t_state    o_state,
    output t_out_word o_word
);

    localparam logic [DATA_W-1:0] WORD_MASK = (WORD_BYTES >= 8) ? {DATA_W{1'b1}} :
        DATA_W'((64'd1 << (WORD_BYTES * 8)) - 64'd1);
    localparam int OFF_W = LEN_W + 4;

    logic              is_start;
    logic [2:0]        iss_p;
    logic [LEN_W-1:0]  iss_idx;
    logic              iss_sel;
    logic              cur_word;
    logic [LEN_W-1:0]  cur_lim;
    logic              found;
    logic [2:0]        q_phase;
    logic [LEN_W-1:0]  q_idx;
    logic              q_sel;
    logic [DATA_W-1:0] pat;
    logic [DATA_W-1:0] xor_val;
    logic [OFF_W-1:0]  offset;
    logic [FIELD_ADDR_W-1:0] q_addr;
    logic [DATA_W-1:0] rd_mask;
    logic              mismatch;

    // where the search for the next operation begins
    assign is_start = (i_word.cmd == CMD_START);
    assign iss_p    = is_start ? PH_WWRITE : i_state.phase;
    assign iss_idx  = is_start ? '0 : i_state.idx;
    assign iss_sel  = is_start ? 1'b0 : i_state.pat_sel;

    // next non-empty phase, wrapping into the second pattern once
    always_comb begin
        cur_word = (iss_p == PH_WWRITE) || (iss_p == PH_WREAD);
        cur_lim  = cur_word ? i_cfg.word_cnt : i_cfg.length;
        found    = 1'b1;
        q_phase  = iss_p;
        q_idx    = iss_idx;
        q_sel    = iss_sel;
        if (iss_idx >= cur_lim) begin
            case (iss_p)
                PH_WWRITE: begin
                    if (i_cfg.has_word) begin
                        q_phase = PH_WREAD;
                        q_idx   = '0;
                    end else if (i_cfg.has_tail) begin
                        q_phase = PH_BWRITE;
                        q_idx   = i_cfg.tail_start;
                    end else begin
                        found = 1'b0;
                    end
                end
                PH_WREAD: begin
                    q_phase = PH_BWRITE;
                    q_idx   = i_cfg.tail_start;
                    found   = i_cfg.has_tail;
                end
                PH_BWRITE: begin
                    q_phase = PH_BREAD;
                    q_idx   = i_cfg.tail_start;
                    found   = i_cfg.has_tail;
                end
                default: begin
                    found = 1'b0;
                end
            endcase
            if (!found && !iss_sel) begin
                found = 1'b1;
                q_sel = 1'b1;
                if (i_cfg.has_word) begin
                    q_phase = PH_WWRITE;
                    q_idx   = '0;
                end else begin
                    q_phase = PH_BWRITE;
                    q_idx   = i_cfg.tail_start;
                end
            end
        end
    end

    // address and data of the chosen operation
    assign pat     = (q_sel ? PAT_SECOND : PAT_FIRST) & WORD_MASK;
    assign xor_val = pat ^ DATA_W'(q_idx);
    assign offset  = ((q_phase == PH_WWRITE) || (q_phase == PH_WREAD)) ?
                     OFF_W'(q_idx) * OFF_W'(WORD_BYTES) : OFF_W'(q_idx);
    assign q_addr  = (i_cfg.base + FIELD_ADDR_W'(offset)) & ADDR_MASK;

    // compare of the outstanding read
    assign rd_mask  = (i_state.phase == PH_BREAD) ? BYTE_MASK : WORD_MASK;
    assign mismatch = i_state.pend_rd && ((i_word.read_data & rd_mask) != i_state.pend_exp);

    // next state and result word
    always_comb begin
        o_state = i_state;
        o_word  = '0;
        if (is_start && ((i_cfg.base == '0) || (i_cfg.length == '0))) begin
            o_state.pend_rd      = 1'b0;
            o_state.pat_sel      = 1'b0;
            o_state.idx          = '0;
            o_state.fail_addr    = '0;
            o_state.phase        = PH_IDLE;
            o_state.final_status = ST_INVALID;
            o_word.status        = ST_INVALID;
            o_word.done_res      = 1'b1;
        end else if (!is_start && (i_state.phase == PH_IDLE)) begin
            o_word.status       = i_state.final_status;
            o_word.fail_address = i_state.fail_addr;
        end else if (!is_start && mismatch) begin
            o_state.pend_rd      = 1'b0;
            o_state.phase        = PH_IDLE;
            o_state.final_status = ST_FAIL;
            o_state.fail_addr    = i_state.pend_addr;
            o_word.status        = ST_FAIL;
            o_word.fail_address  = i_state.pend_addr;
            o_word.done_res      = 1'b1;
        end else begin
            o_state.pend_rd = 1'b0;
            if (is_start) begin
                o_state.fail_addr    = '0;
                o_state.final_status = ST_RUN;
            end
            if (!found) begin
                // both passes finished
                o_state.phase        = PH_IDLE;
                o_state.pat_sel      = q_sel;
                o_state.idx          = q_idx;
                o_state.final_status = ST_PASS;
                o_state.fail_addr    = '0;
                o_word.status        = ST_PASS;
                o_word.done_res      = 1'b1;
            end else begin
                o_state.phase   = q_phase;
                o_state.pat_sel = q_sel;
                o_state.idx     = q_idx + LEN_W'(1);
                o_word.mem_addr = q_addr;
                case (q_phase)
                    PH_WWRITE: begin
                        o_word.mem_op     = OP_WWORD;
                        o_word.write_data = xor_val & WORD_MASK;
                    end
                    PH_WREAD: begin
                        o_word.mem_op     = OP_RWORD;
                        o_state.pend_exp  = xor_val & WORD_MASK;
                        o_state.pend_addr = q_addr;
                        o_state.pend_rd   = 1'b1;
                    end
                    PH_BWRITE: begin
                        o_word.mem_op     = OP_WBYTE;
                        o_word.write_data = xor_val & BYTE_MASK;
                    end
                    default: begin
                        o_word.mem_op     = OP_RBYTE;
                        o_state.pend_exp  = xor_val & BYTE_MASK;
                        o_state.pend_addr = q_addr;
                        o_state.pend_rd   = 1'b1;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/memory_xor_pattern_bist.sv
// ----------------------------------------------------------------------------
// memory_xor_pattern_bist
// Address-xor pattern memory self-test sequencer, one step per word.
// ----------------------------------------------------------------------------
// Usage:
//   The region is set through the register port (index 0 base address,
//   index 1 length in bytes); the port is always ready.
//   An input word with cmd 0 starts a test and yields the first memory
//   operation. Each input word with cmd 1 carries the read data for the
//   previous read operation and yields the next operation. The final
//   result of a run has done_res set with the pass, fail or invalid status.
//   Each input word is held in the input register, and its result word
//   is then held in the result register.
//   Throughput: one input word per cycle while the receiver does not stall,
//   as the step runs combinationally from the input register through the
//   compare and address adder into the result register.
//   Reset clears the region registers, the sequencer state and both
//   register stages; the block is idle with status zero.
//   When the receiver stalls, the result word holds and the input side
//   stalls once the input register is also full.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_xor_pattern_bist
    import mxb_pkg::*;
#(
    parameter int WORD_BYTES = DEF_WORD_BYTES
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  t_in_word                     i_in_data,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output t_out_word                    o_out_data,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [FIELD_ADDR_W-1:0] i_cfg_data
);

    t_cfg      cfg;
    t_state    r_state;
    t_state    n_state;
    t_in_word  r_in;
    logic      r_in_valid;
    t_out_word r_out;
    t_out_word n_out;
    logic      r_out_valid;
    logic      step_en;

    // region registers
    assign o_cfg_ready = 1'b1;

    mxb_cfg #(
        .WORD_BYTES(WORD_BYTES)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid & o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // step logic
    mxb_step #(
        .WORD_BYTES(WORD_BYTES)
    ) u_step (
        .i_cfg  (cfg),
        .i_state(r_state),
        .i_word (r_in),
        .o_state(n_state),
        .o_word (n_out)
    );

    // handshake: a step runs when the result register is free or draining
    assign step_en    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !step_en;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (step_en) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_en) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

FILE: tb/sv/memory_xor_pattern_bist_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// memory_xor_pattern_bist_tb
// Self-checking bench for the address-xor pattern memory self-test sequencer.
// A short stimulus table covers the invalid regions, pass, both compare
// failures, restart and address wrap. Random sessions follow, mostly complete
// runs answered with correct read data and a few corrupted reads. Every
// result word is checked against a typed table entry or an in-bench model.
// ----------------------------------------------------------------------------

module memory_xor_pattern_bist_tb;
    import mxb_pkg::*;

    localparam int WB = DEF_WORD_BYTES;
    localparam logic [DATA_W-1:0] WMASK =
        (WB >= 8) ? {DATA_W{1'b1}} : ((64'd1 << (WB * 8)) - 64'd1);

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam int RANDOM_ITEMS = 1600;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 8;

    localparam t_out_word NO_WORD = '0;

    typedef enum logic [1:0] {RD_GOOD, RD_BAD, RD_NOISE} rd_kind_e;
    typedef enum logic [2:0] {
        STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY, STALL_TOGGLE
    } stall_mode_e;

    typedef struct {
        logic      set_cfg;
        logic [FIELD_ADDR_W-1:0] base;
        logic [FIELD_ADDR_W-1:0] len_word;
        logic      cmd;
        rd_kind_e  rd;
        int        reps;
        logic      typed;
        t_out_word want;
    } stim_row_t;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    t_in_word                i_in_data;
    logic                    o_out_valid;
    logic                    i_out_stall;
    t_out_word               o_out_data;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [FIELD_ADDR_W-1:0] i_cfg_data;

    // sequencer model state, starts at its reset values
    logic [FIELD_ADDR_W-1:0] seq_base      = '0;
    logic [LEN_W-1:0]        seq_len       = '0;
    logic [2:0]              seq_phase     = PH_IDLE;
    logic                    seq_pat_hi    = 1'b0;
    logic [LEN_W-1:0]        seq_idx       = '0;
    logic [DATA_W-1:0]       seq_chk_data  = '0;
    logic [FIELD_ADDR_W-1:0] seq_chk_addr  = '0;
    logic                    seq_chk_busy  = 1'b0;
    logic [FIELD_ADDR_W-1:0] seq_fail_addr = '0;
    logic [1:0]              seq_status    = ST_RUN;

    t_out_word due_q[$];
    int        mismatch_cnt = 0;
    int        words_seen   = 0;
    int        live_items   = 0;
    int        burst_left   = 0;

    memory_xor_pattern_bist dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3ms;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic t_out_word mk_word(logic [2:0] op, logic [FIELD_ADDR_W-1:0] addr,
                                          logic [DATA_W-1:0] data, logic [1:0] st,
                                          logic [FIELD_ADDR_W-1:0] fail, logic done);
        t_out_word w;
        w.mem_op       = op;
        w.mem_addr     = addr;
        w.write_data   = data;
        w.status       = st;
        w.fail_address = fail;
        w.done_res     = done;
        return w;
    endfunction

    function automatic logic [FIELD_ADDR_W-1:0] region_addr(logic [63:0] offset);
        return FIELD_ADDR_W'((64'(seq_base) + offset) & 64'(ADDR_MASK));
    endfunction

    // next memory operation of the running test, empty phases skipped
    function automatic t_out_word next_mem_op();
        logic [63:0] wc;
        logic [63:0] tail0;
        logic [63:0] pat;
        logic [63:0] idx;
        t_out_word   w;
        logic        found;
        int          g;
        wc    = 64'(seq_len) / 64'(WB);
        tail0 = wc * 64'(WB);
        pat   = (seq_pat_hi ? PAT_SECOND : PAT_FIRST) & WMASK;
        found = 1'b0;
        w     = NO_WORD;
        for (g = 0; g < 16 && !found; g++) begin
            idx = 64'(seq_idx);
            case (seq_phase)
                PH_WWRITE: begin
                    if (idx < wc) begin
                        seq_idx = LEN_W'(idx + 1);
                        w = mk_word(OP_WWORD, region_addr(idx * 64'(WB)), (pat ^ idx) & WMASK,
                                    ST_RUN, '0, 1'b0);
                        found = 1'b1;
                    end else begin
                        seq_phase = PH_WREAD;
                        seq_idx   = '0;
                    end
                end
                PH_WREAD: begin
                    if (idx < wc) begin
                        seq_idx      = LEN_W'(idx + 1);
                        seq_chk_data = (pat ^ idx) & WMASK;
                        seq_chk_addr = region_addr(idx * 64'(WB));
                        seq_chk_busy = 1'b1;
                        w = mk_word(OP_RWORD, seq_chk_addr, '0, ST_RUN, '0, 1'b0);
                        found = 1'b1;
                    end else begin
                        seq_phase = PH_BWRITE;
                        seq_idx   = LEN_W'(tail0);
                    end
                end
                PH_BWRITE: begin
                    if (idx < 64'(seq_len)) begin
                        seq_idx = LEN_W'(idx + 1);
                        w = mk_word(OP_WBYTE, region_addr(idx), (pat ^ idx) & BYTE_MASK,
                                    ST_RUN, '0, 1'b0);
                        found = 1'b1;
                    end else begin
                        seq_phase = PH_BREAD;
                        seq_idx   = LEN_W'(tail0);
                    end
                end
                PH_BREAD: begin
                    if (idx < 64'(seq_len)) begin
                        seq_idx      = LEN_W'(idx + 1);
                        seq_chk_data = (pat ^ idx) & BYTE_MASK;
                        seq_chk_addr = region_addr(idx);
                        seq_chk_busy = 1'b1;
                        w = mk_word(OP_RBYTE, seq_chk_addr, '0, ST_RUN, '0, 1'b0);
                        found = 1'b1;
                    end else if (!seq_pat_hi) begin
                        // second pass with the inverted pattern
                        seq_pat_hi = 1'b1;
                        pat        = PAT_SECOND & WMASK;
                        seq_phase  = PH_WWRITE;
                        seq_idx    = '0;
                    end else begin
                        seq_phase     = PH_IDLE;
                        seq_status    = ST_PASS;
                        seq_fail_addr = '0;
                        w = mk_word(OP_NONE, '0, '0, ST_PASS, '0, 1'b1);
                        found = 1'b1;
                    end
                end
                default: begin
                    seq_phase = PH_IDLE;
                    w = mk_word(OP_NONE, '0, '0, seq_status, seq_fail_addr, 1'b0);
                    found = 1'b1;
                end
            endcase
        end
        if (!found) begin
            seq_phase = PH_IDLE;
            w = mk_word(OP_NONE, '0, '0, seq_status, seq_fail_addr, 1'b0);
        end
        return w;
    endfunction

    // one input word through the sequencer model
    function automatic t_out_word step_sequencer(t_in_word in_w);
        t_out_word   w;
        logic [63:0] mask;
        logic        failed;
        failed = 1'b0;
        if (in_w.cmd == CMD_START) begin
            seq_chk_busy  = 1'b0;
            seq_pat_hi    = 1'b0;
            seq_idx       = '0;
            seq_fail_addr = '0;
            if (seq_base == '0 || seq_len == '0) begin
                seq_phase  = PH_IDLE;
                seq_status = ST_INVALID;
                w = mk_word(OP_NONE, '0, '0, ST_INVALID, '0, 1'b1);
            end else begin
                seq_status = ST_RUN;
                seq_phase  = PH_WWRITE;
                w = next_mem_op();
            end
        end else if (seq_phase == PH_IDLE) begin
            w = mk_word(OP_NONE, '0, '0, seq_status, seq_fail_addr, 1'b0);
        end else begin
            if (seq_chk_busy) begin
                mask = (seq_phase == PH_BREAD) ? BYTE_MASK : WMASK;
                seq_chk_busy = 1'b0;
                if ((in_w.read_data & mask) != seq_chk_data) begin
                    seq_phase     = PH_IDLE;
                    seq_status    = ST_FAIL;
                    seq_fail_addr = seq_chk_addr;
                    w = mk_word(OP_NONE, '0, '0, ST_FAIL, seq_chk_addr, 1'b1);
                    failed = 1'b1;
                end
            end
            if (!failed) begin
                w = next_mem_op();
            end
        end
        return w;
    endfunction

    // read data answering the outstanding read, right, corrupted or junk
    function automatic logic [DATA_W-1:0] read_data_for(rd_kind_e kind);
        logic [DATA_W-1:0] junk;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] good;
        int                top;
        junk = {$urandom, $urandom};
        if (kind == RD_NOISE || !seq_chk_busy) begin
            return junk;
        end
        mask = (seq_phase == PH_BREAD) ? BYTE_MASK : WMASK;
        top  = (seq_phase == PH_BREAD) ? 7 : WB * 8 - 1;
        good = (junk & ~mask) | seq_chk_data;
        if (kind == RD_BAD) begin
            good = good ^ (64'd1 << $urandom_range(0, top));
        end
        return good;
    endfunction

    // predict, then offer the word in bursts with random gaps
    task automatic send_word(logic cmd, logic [DATA_W-1:0] rd, logic typed, t_out_word want);
        t_in_word  w;
        t_out_word pred;
        w.cmd       = cmd;
        w.read_data = rd;
        if (cmd == CMD_START || seq_phase != PH_IDLE) begin
            live_items++;
        end
        pred = step_sequencer(w);
        due_q.push_back(typed ? want : pred);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (due_q.size() != 0);
        @(posedge i_clk);
    endtask

    // base and length, now and then a write to an unused index
    task automatic write_region(logic [FIELD_ADDR_W-1:0] base,
                                logic [FIELD_ADDR_W-1:0] len_word);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_BASE;
        i_cfg_data  <= base;
        do @(posedge i_clk); while (!o_cfg_ready);
        seq_base = base;
        i_cfg_index <= CFG_LENGTH;
        i_cfg_data  <= len_word;
        do @(posedge i_clk); while (!o_cfg_ready);
        seq_len = len_word[LEN_W-1:0];
        if ($urandom_range(0, 2) == 0) begin
            i_cfg_index <= ($urandom_range(0, 1) == 1) ? CFG_SPARE_LO : CFG_SPARE_HI;
            i_cfg_data  <= FIELD_ADDR_W'({$urandom, $urandom});
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // one random session: new region or not, usually a start, run mostly with good reads
    task automatic run_session();
        int                      pick;
        int                      budget;
        int                      n;
        int                      r;
        logic [FIELD_ADDR_W-1:0] base;
        logic [LEN_W-1:0]        len;
        wait_drained();
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
            case ($urandom_range(0, 15))
                0: base = '0;
                1: base = 48'hFFFF_FFFF_FF00 | FIELD_ADDR_W'($urandom_range(0, 255));
                default: base = {16'($urandom), 32'($urandom)};
            endcase
            r = $urandom_range(0, 15);
            if (r == 0) begin
                len = '0;
            end else if (r == 1) begin
                len = $urandom;
            end else begin
                len = $urandom_range(1, 40);
            end
            write_region(base, {16'($urandom), len});
        end
        budget = (seq_len > 64) ? $urandom_range(4, 60) : 1000;
        if (pick != 9) begin
            send_word(CMD_START, {$urandom, $urandom}, 1'b0, NO_WORD);
        end
        n = 0;
        while (seq_phase != PH_IDLE && n < budget) begin
            r = $urandom_range(0, 239);
            if (r == 0) begin
                send_word(CMD_START, {$urandom, $urandom}, 1'b0, NO_WORD);
            end else begin
                send_word(CMD_ADVANCE,
                          read_data_for(r < 3 ? RD_BAD : (r < 5 ? RD_NOISE : RD_GOOD)),
                          1'b0, NO_WORD);
            end
            n++;
        end
        repeat ($urandom_range(0, 2)) send_word(CMD_ADVANCE, {$urandom, $urandom}, 1'b0,
                                                NO_WORD);
    endtask

    // compare each result word with the oldest prediction
    always @(posedge i_clk) begin : chk_results
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            words_seen++;
            if (due_q.size() == 0) begin
                $error("result word with nothing pending: %h", o_out_data);
                mismatch_cnt++;
            end else begin
                want = due_q.pop_front();
                if (o_out_data.mem_op !== want.mem_op) begin
                    $error("mem_op: expected %0d, got %0d", want.mem_op, o_out_data.mem_op);
                    mismatch_cnt++;
                end
                if (o_out_data.mem_addr !== want.mem_addr) begin
                    $error("mem_addr: expected %h, got %h", want.mem_addr,
                           o_out_data.mem_addr);
                    mismatch_cnt++;
                end
                if (o_out_data.write_data !== want.write_data) begin
                    $error("write_data: expected %h, got %h", want.write_data,
                           o_out_data.write_data);
                    mismatch_cnt++;
                end
                if (o_out_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_data.status);
                    mismatch_cnt++;
                end
                if (o_out_data.fail_address !== want.fail_address) begin
                    $error("fail_address: expected %h, got %h", want.fail_address,
                           o_out_data.fail_address);
                    mismatch_cnt++;
                end
                if (o_out_data.done_res !== want.done_res) begin
                    $error("done_res: expected %0d, got %0d", want.done_res,
                           o_out_data.done_res);
                    mismatch_cnt++;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off to back up the input
    initial begin : rx_stall
        int          seg;
        int          k;
        stall_mode_e mode;
        logic        held;
        held = 1'b0;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!held && words_seen >= HOLD_AFTER) begin
                held = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            seg  = $urandom_range(16, 160);
            mode = stall_mode_e'($urandom_range(0, 4));
            for (k = 0; k < seg; k++) begin
                case (mode)
                    STALL_NONE:  i_out_stall <= 1'b0;
                    STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HALF:  i_out_stall <= ($urandom_range(0, 1) == 1);
                    STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default:     i_out_stall <= k[0];
                endcase
                @(posedge i_clk);
            end
        end
    end

    // main stimulus
    initial begin : stim
        stim_row_t tab [22];
        int        n;
        int        live_start;

        // directed table: cfg flag, base, length word, cmd, read data, repeats,
        // typed flag, typed result
        tab[0]  = '{1'b0, 48'h0, 48'h0, CMD_ADVANCE, RD_NOISE, 1, 1'b1,
                    '{OP_NONE, 48'h0, 64'h0, ST_RUN, 48'h0, 1'b0}};
        tab[1]  = '{1'b1, 48'h0, 48'h0, CMD_START, RD_NOISE, 1, 1'b1,
                    '{OP_NONE, 48'h0, 64'h0, ST_INVALID, 48'h0, 1'b1}};
        tab[2]  = '{1'b0, 48'h0, 48'h0, CMD_ADVANCE, RD_NOISE, 1, 1'b1,
                    '{OP_NONE, 48'h0, 64'h0, ST_INVALID, 48'h0, 1'b0}};
        tab[3]  = '{1'b1, 48'h1000, 48'h0, CMD_START, RD_NOISE, 1, 1'b1,
                    '{OP_NONE, 48'h0, 64'h0, ST_INVALID, 48'h0, 1'b1}};
        tab[4]  = '{1'b1, 48'h0, 48'h10, CMD_START, RD_NOISE, 1, 1'b1,
                    '{OP_NONE, 48'h0, 64'h0, ST_INVALID, 48'h0, 1'b1}};
        // one tail byte at the top address, run to pass
        tab[5]  = '{1'b1, 48'hFFFF_FFFF_FFFF, 48'h1, CMD_START, RD_NOISE, 1, 1'b1,
                    '{OP_WBYTE, 48'hFFFF_FFFF_FFFF, 64'h5A, ST_RUN, 48'h0, 1'b0}};
        tab[6]  = '{1'b0, 48'h0, 48'h0, CMD_ADVANCE, RD_GOOD, 4, 1'b0, NO_WORD};
        tab[7]  = '{1'b0, 48'h0, 48'h0, CMD_ADVANCE, RD_NOISE, 1, 1'b1,
                    '{OP_NONE, 48'h0, 64'h0, ST_PASS, 48'h0, 1'b0}};
        // word compare failure
        tab[8]  = '{1'b1, 48'h100, 48'h8, CMD_START, RD_NOISE, 1, 1'b0, NO_WORD};
        tab[9]  = '{1'b0, 48'h0, 48'h0, CMD_ADVANCE, RD_GOOD, 1, 1'b0, NO_WORD};
        tab[10] = '{1'b0, 48'h0, 48'h0, CMD_ADVANCE, RD_BAD, 1, 1'b1,
                    '{OP_NONE, 48'h0, 64'h0, ST_FAIL, 48'h100, 1'b1}};
        tab[11] = '{1'b0, 48'h0, 48'h0, CMD_ADVANCE, RD_NOISE, 1, 1'b1,
                    '{OP_NONE, 48'h0, 64'h0, ST_FAIL, 48'h100, 1'b0}};
        // tail only region, byte compare failure
        tab[12] = '{1'b1, 48'h2000, 48'h3, CMD_START, RD_NOISE, 1, 1'b1,
                    '{OP_WBYTE, 48'h2000, 64'h5A, ST_RUN, 48'h0, 1'b0}};
        tab[13] = '{1'b0, 48'h0, 48'h0, CMD_ADVANCE, RD_GOOD, 3, 1'b0, NO_WORD};
        tab[14] = '{1'b0, 48'h0, 48'h0, CMD_ADVANCE, RD_BAD, 1, 1'b1,
                    '{OP_NONE, 48'h0, 64'h0, ST_FAIL, 48'h2000, 1'b1}};
        // restart while running
        tab[15] = '{1'b1, 48'h3000, 48'h1000, CMD_START, RD_NOISE, 1, 1'b0, NO_WORD};
        tab[16] = '{1'b0, 48'h0, 48'h0, CMD_ADVANCE, RD_GOOD, 2, 1'b0, NO_WORD};
        tab[17] = '{1'b0, 48'h0, 48'h0, CMD_START, RD_NOISE, 1, 1'b1,
                    '{OP_WWORD, 48'h3000, PAT_FIRST, ST_RUN, 48'h0, 1'b0}};
        tab[18] = '{1'b0, 48'h0, 48'h0, CMD_ADVANCE, RD_GOOD, 1, 1'b0, NO_WORD};
        // region shrunk under a running test, junk in the upper length bits
        tab[19] = '{1'b1, 48'h40, 48'hABCD_0000_0004, CMD_ADVANCE, RD_GOOD, 6, 1'b0,
                    NO_WORD};
        // largest base and length, word addresses wrap
        tab[20] = '{1'b1, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF, CMD_START, RD_NOISE, 1, 1'b1,
                    '{OP_WWORD, 48'hFFFF_FFFF_FFFF, PAT_FIRST, ST_RUN, 48'h0, 1'b0}};
        tab[21] = '{1'b0, 48'h0, 48'h0, CMD_ADVANCE, RD_GOOD, 2, 1'b0, NO_WORD};

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_BASE;
        i_cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (tab[r]) begin
            if (tab[r].set_cfg) begin
                wait_drained();
                write_region(tab[r].base, tab[r].len_word);
            end
            for (n = 0; n < tab[r].reps; n++) begin
                send_word(tab[r].cmd, read_data_for(tab[r].rd), tab[r].typed, tab[r].want);
            end
        end

        live_start = live_items;
        while (live_items - live_start < RANDOM_ITEMS) begin
            run_session();
        end

        // drain, then watch for any unexpected result word
        i_in_valid <= 1'b0;
        n = 0;
        while (due_q.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        if (n >= DRAIN_LIMIT) begin
            $display("end of test: mismatches");
        end else begin
            repeat (TAIL_CYCLES) @(posedge i_clk);
            if (mismatch_cnt == 0) begin
                $display("end of test: clean");
            end else begin
                $display("end of test: mismatches");
            end
        end
        $finish;
    end

endmodule
